@@ rtl/core/lru_block_buffer_cache_unit_assert.svh @@
// assertion macros for the lru block buffer cache unit
// expects aclk and aresetn in the scope of the including module
`ifndef LRU_BLOCK_BUFFER_CACHE_UNIT_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LBC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lbc_pkg.sv @@
// shared types and constants of the lru block buffer cache unit
// no dependencies
package lbc_pkg;

    localparam int BLK_W         = 16;
    localparam int STAMP_W       = 16;
    localparam int KIND_W        = 3;
    localparam int SLOT_W        = 6;
    localparam int CMD_W         = 2;
    localparam int ENTRIES_DEF   = 8;

    localparam logic [BLK_W-1:0] TAG_FREE      = 16'hFFFF;
    localparam logic [BLK_W-1:0] MAX_BLOCK_RST = 16'hFFFE;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCESS     = 2'd0,
        CMD_MARK_DIRTY = 2'd1,
        CMD_FLUSH_ONE  = 2'd2,
        CMD_FLUSH_ALL  = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT  = 3'd0,
        KIND_FILL = 3'd1,
        KIND_WB   = 3'd2,
        KIND_ERR  = 3'd3,
        KIND_DONE = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ERR,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_RESOLVE,
        ST_WB_VICTIM,
        ST_FILL,
        ST_HIT,
        ST_FL1_WB,
        ST_DONE,
        ST_FA_RD,
        ST_FA_CHK,
        ST_FA_DONE
    } state_t;

    // tag and age stamp of one slot as held in the slot store
    typedef struct packed {
        logic [BLK_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } slot_data_t;

    // flags from the shared compare unit
    typedef struct packed {
        logic tag_eq;
        logic stamp_lt;
    } cmp_res_t;

endpackage

@@ rtl/core/lbc_slot_store.sv @@
// slot store: tag and stamp memory, one write port and one registered read port
// depends on lbc_pkg
module lbc_slot_store
    import lbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  slot_data_t       wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output slot_data_t       rd_data
);

    slot_data_t mem [ENTRIES];
    slot_data_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/lbc_cmp_unit.sv @@
// shared compare unit: tag equality and stamp less-than
// depends on lbc_pkg
module lbc_cmp_unit
    import lbc_pkg::*;
(
    input  logic [BLK_W-1:0]   a_tag,
    input  logic [BLK_W-1:0]   b_tag,
    input  logic [STAMP_W-1:0] a_stamp,
    input  logic [STAMP_W-1:0] b_stamp,
    output cmp_res_t           res
);

    assign res.tag_eq   = (a_tag == b_tag);
    assign res.stamp_lt = (a_stamp < b_stamp);

endmodule

@@ rtl/core/lru_block_buffer_cache_unit.sv @@
// top level of the lru block buffer cache unit: sequencer, slot flags, output register
// depends on lbc_pkg, lbc_slot_store, lbc_cmp_unit and the assertion header
//
// Fully associative write-back cache directory with ENTRIES slots and LRU
// replacement. One command is taken at a time; s_ready is high only while
// the sequencer is idle, and the final result may still sit in the output
// register when the next command is taken. A lookup command (access, mark
// dirty, flush one) walks every slot once through the single read port of
// the slot store and the shared compare unit. Flush one, once past the
// range check, always passes through its writeback check, which emits no
// result for a clean slot. Flush all reads every slot in turn, a read
// state then a check state for each, its writebacks leaving during the
// check states. Stalls on m_ready hold the sequencer in any state that has
// a result to emit. Valid and dirty flags live in flip-flops and reset at
// once; there is no clearing pass. max_block is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block
// is idle, as the block itself does not enforce it.
module lru_block_buffer_cache_unit
    import lbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [BLK_W-1:0]  cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [BLK_W-1:0]  s_block_number,
    input  logic              s_clear_entry,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_kind,
    output logic [BLK_W-1:0]  m_block_out,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_last
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic   clr_reg, clr_next;
    logic [BLK_W-1:0] max_block_reg;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg;

    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             min_found_reg, min_found_next;
    logic [IDX_W-1:0] min_idx_reg, min_idx_next;
    logic [STAMP_W-1:0] min_stamp_reg, min_stamp_next;
    logic [BLK_W-1:0] min_tag_reg, min_tag_next;
    logic [IDX_W-1:0] tgt_idx_reg, tgt_idx_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] dirty_reg, dirty_next;
    logic [STAMP_W-1:0] counter_reg, counter_next;
    logic [STAMP_W-1:0] stamp_new;

    logic              m_valid_reg, m_valid_next;
    kind_t             m_kind_reg, m_kind_next;
    logic [BLK_W-1:0]  m_block_reg, m_block_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic              m_last_reg, m_last_next;
    logic              out_free;

    logic       wr_en;
    slot_data_t wr_data;
    slot_data_t rd_data;

    logic [BLK_W-1:0]   cmp_a_tag, cmp_b_tag;
    logic [STAMP_W-1:0] cmp_a_stamp, cmp_b_stamp;
    cmp_res_t           cmp_res;
    logic               pend_valid_slot;

    lbc_slot_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tgt_idx_reg),
        .wr_data (wr_data),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    lbc_cmp_unit u_cmp (
        .a_tag   (cmp_a_tag),
        .b_tag   (cmp_b_tag),
        .a_stamp (cmp_a_stamp),
        .b_stamp (cmp_b_stamp),
        .res     (cmp_res)
    );

    assign out_free        = !m_valid_reg || m_ready;
    assign stamp_new       = counter_reg + STAMP_W'(1);
    assign pend_valid_slot = valid_reg[pend_idx_reg];
    assign wr_data.tag     = blk_reg;
    assign wr_data.stamp   = stamp_new;

    // compare operands: range check while checking, slot data while scanning
    always_comb begin
        if (state_reg == ST_CHECK) begin
            cmp_a_tag   = blk_reg;
            cmp_b_tag   = TAG_FREE;
            cmp_a_stamp = max_block_reg;
            cmp_b_stamp = blk_reg;
        end else begin
            cmp_a_tag   = rd_data.tag;
            cmp_b_tag   = blk_reg;
            cmp_a_stamp = rd_data.stamp;
            cmp_b_stamp = min_stamp_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        blk_next        = blk_reg;
        clr_next        = clr_reg;
        scan_idx_next   = scan_idx_reg;
        pend_vld_next   = 1'b0;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        min_found_next  = min_found_reg;
        min_idx_next    = min_idx_reg;
        min_stamp_next  = min_stamp_reg;
        min_tag_next    = min_tag_reg;
        tgt_idx_next    = tgt_idx_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        counter_next    = counter_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_block_next    = m_block_reg;
        m_slot_next     = m_slot_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;
        s_ready         = 1'b0;

        // slot data read last cycle arrives now
        if (pend_vld_reg) begin
            if (pend_valid_slot && cmp_res.tag_eq) begin
                hit_found_next = 1'b1;
                hit_idx_next   = pend_idx_reg;
            end
            if (!pend_valid_slot && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = pend_idx_reg;
            end
            // strict less keeps the lowest slot on ties
            if (pend_valid_slot && (!min_found_reg || cmp_res.stamp_lt)) begin
                min_found_next = 1'b1;
                min_idx_next   = pend_idx_reg;
                min_stamp_next = rd_data.stamp;
                min_tag_next   = rd_data.tag;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next      = cmd_t'(s_command);
                    blk_next      = s_block_number;
                    clr_next      = s_clear_entry;
                    scan_idx_next = '0;
                    if (cmd_t'(s_command) == CMD_FLUSH_ALL) begin
                        state_next = ST_FA_RD;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // free marker or above the limit
                if (cmp_res.tag_eq || cmp_res.stamp_lt) begin
                    state_next = ST_ERR;
                end else begin
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    min_found_next  = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ERR;
                    m_block_next = blk_reg;
                    m_slot_next  = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                pend_vld_next = 1'b1;
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_SCAN_TAIL;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_SCAN_TAIL: begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (hit_found_reg) begin
                    tgt_idx_next = hit_idx_reg;
                    state_next   = ST_HIT;
                end else if (free_found_reg) begin
                    tgt_idx_next = free_idx_reg;
                    state_next   = ST_FILL;
                end else begin
                    tgt_idx_next = min_idx_reg;
                    state_next   = dirty_reg[min_idx_reg] ? ST_WB_VICTIM : ST_FILL;
                end
            end
            ST_WB_VICTIM: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_kind_next             = KIND_WB;
                    m_block_next            = min_tag_reg;
                    m_slot_next             = SLOT_W'(tgt_idx_reg);
                    m_last_next             = 1'b0;
                    dirty_next[tgt_idx_reg] = 1'b0;
                    state_next              = ST_FILL;
                end
            end
            ST_HIT, ST_FILL: begin
                if (out_free) begin
                    wr_en        = 1'b1;
                    counter_next = stamp_new;
                    m_valid_next = 1'b1;
                    m_kind_next  = (state_reg == ST_HIT) ? KIND_HIT : KIND_FILL;
                    m_block_next = blk_reg;
                    m_slot_next  = SLOT_W'(tgt_idx_reg);
                    m_last_next  = (cmd_reg != CMD_FLUSH_ONE);
                    if (state_reg == ST_FILL) begin
                        valid_next[tgt_idx_reg] = 1'b1;
                        dirty_next[tgt_idx_reg] = 1'b0;
                    end
                    if (cmd_reg == CMD_MARK_DIRTY) begin
                        dirty_next[tgt_idx_reg] = 1'b1;
                    end
                    state_next = (cmd_reg == CMD_FLUSH_ONE) ? ST_FL1_WB : ST_IDLE;
                end
            end
            ST_FL1_WB: begin
                if (!dirty_reg[tgt_idx_reg] || out_free) begin
                    if (dirty_reg[tgt_idx_reg]) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_WB;
                        m_block_next = blk_reg;
                        m_slot_next  = SLOT_W'(tgt_idx_reg);
                        m_last_next  = 1'b0;
                    end
                    dirty_next[tgt_idx_reg] = 1'b0;
                    if (clr_reg) begin
                        valid_next[tgt_idx_reg] = 1'b0;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_DONE;
                    m_block_next = '0;
                    m_slot_next  = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FA_RD: begin
                state_next = ST_FA_CHK;
            end
            ST_FA_CHK: begin
                // a dirty slot is always valid, so its stored tag is live
                if (!dirty_reg[scan_idx_reg] || out_free) begin
                    if (dirty_reg[scan_idx_reg]) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_WB;
                        m_block_next = rd_data.tag;
                        m_slot_next  = SLOT_W'(scan_idx_reg);
                        m_last_next  = 1'b0;
                    end
                    dirty_next[scan_idx_reg] = 1'b0;
                    if (scan_idx_reg == LAST_IDX) begin
                        state_next = ST_FA_DONE;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                        state_next    = ST_FA_RD;
                    end
                end
            end
            ST_FA_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_DONE;
                    m_block_next = '0;
                    m_slot_next  = '0;
                    m_last_next  = 1'b1;
                    if (clr_reg) begin
                        valid_next   = '0;
                        counter_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            counter_reg   <= '0;
            max_block_reg <= MAX_BLOCK_RST;
            m_valid_reg   <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            counter_reg  <= counter_next;
            m_valid_reg  <= m_valid_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_wr_en) begin
                max_block_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        blk_reg        <= blk_next;
        clr_reg        <= clr_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= scan_idx_reg;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        min_found_reg  <= min_found_next;
        min_idx_reg    <= min_idx_next;
        min_stamp_reg  <= min_stamp_next;
        min_tag_reg    <= min_tag_next;
        tgt_idx_reg    <= tgt_idx_next;
        m_kind_reg     <= m_kind_next;
        m_block_reg    <= m_block_next;
        m_slot_reg     <= m_slot_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_block_out = m_block_reg;
    assign m_slot      = m_slot_reg;
    assign m_last      = m_last_reg;

`include "lru_block_buffer_cache_unit_assert.svh"

    // a new transaction never overtakes an unfinished result sequence
    `LBC_ASSERT_IMP(a_no_overtake, s_valid && s_ready,
        !(m_valid && !m_last), "input taken mid-sequence")
    // dirty slots are always valid
    `LBC_ASSERT_IMP(a_dirty_valid, 1'b1,
        (dirty_reg & ~valid_reg) == '0, "dirty flag on a free slot")
    // tags stay unique, so a second hit in one scan is a slip
    `LBC_ASSERT_IMP(a_single_hit, pend_vld_reg && hit_found_reg && pend_valid_slot,
        !cmp_res.tag_eq, "block present in two slots")
    // flush all with clear empties the whole directory
    `LBC_ASSERT_NXT(a_flush_clear, state_reg == ST_FA_DONE && out_free && clr_reg,
        valid_reg == '0 && dirty_reg == '0 && counter_reg == '0,
        "flush all left entries behind")

endmodule

@@ tb/sv/lbc_dir_checker.sv @@
// checker of the lru block buffer cache unit: keeps a directory model, predicts and compares
// depends on lbc_pkg; sees only the ports of the block
module lbc_dir_checker
    import lbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [BLK_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [BLK_W-1:0]  s_block_number,
    input  logic              s_clear_entry,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [KIND_W-1:0] m_kind,
    input  logic [BLK_W-1:0]  m_block_out,
    input  logic [SLOT_W-1:0] m_slot,
    input  logic              m_last,
    output int                fail_count,
    output int                pending,
    output int                results_seen,
    output int                hits_seen,
    output int                wbs_seen,
    output int                errs_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t              kind;
        logic [BLK_W-1:0]   blk;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } dir_result_t;

    logic [BLK_W-1:0]   tag_q [ENTRIES];
    logic [STAMP_W-1:0] stamp_q [ENTRIES];
    logic               dirty_q [ENTRIES];
    logic [STAMP_W-1:0] use_cnt;
    logic [BLK_W-1:0]   limit_q;
    dir_result_t        expected_q [$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        hits_seen    = 0;
        wbs_seen     = 0;
        errs_seen    = 0;
    end

    task automatic report_mismatch(input string what, input dir_result_t got,
                                   input dir_result_t want);
        $display({"%0t mismatch (%s): got kind %0d block %h slot %0d last %b, ",
                  "want kind %0d block %h slot %0d last %b"},
                 $realtime, what, got.kind, got.blk, got.slot, got.last,
                 want.kind, want.blk, want.slot, want.last);
        fail_count++;
    endtask

    task automatic push_result(input kind_t kind, input logic [BLK_W-1:0] blk, input int s);
        dir_result_t r;
        r.kind = kind;
        r.blk  = blk;
        r.slot = SLOT_W'(s);
        r.last = 1'b0;
        expected_q.push_back(r);
    endtask

    task automatic free_entry(input int s);
        tag_q[s]   = TAG_FREE;
        stamp_q[s] = '0;
        dirty_q[s] = 1'b0;
    endtask

    // hit, or [writeback of victim] then fill; slot is -1 after an error
    task automatic lookup_block(input logic [BLK_W-1:0] blk, output int slot);
        int               victim;
        victim = -1;
        slot   = -1;
        if (blk == TAG_FREE || blk > limit_q) begin
            push_result(KIND_ERR, blk, 0);
            return;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && tag_q[i] == blk) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            use_cnt = use_cnt + 1'b1;
            stamp_q[slot] = use_cnt;
            push_result(KIND_HIT, blk, slot);
            return;
        end
        // first free slot wins, else least stamp with the lowest slot on ties
        for (int i = 0; i < ENTRIES; i++) begin
            if (victim < 0 || tag_q[victim] != TAG_FREE) begin
                if (tag_q[i] == TAG_FREE) begin
                    victim = i;
                end else if (victim < 0 || stamp_q[i] < stamp_q[victim]) begin
                    victim = i;
                end
            end
        end
        if (dirty_q[victim]) begin
            push_result(KIND_WB, tag_q[victim], victim);
        end
        tag_q[victim]   = blk;
        use_cnt         = use_cnt + 1'b1;
        stamp_q[victim] = use_cnt;
        dirty_q[victim] = 1'b0;
        push_result(KIND_FILL, blk, victim);
        slot = victim;
    endtask

    task automatic predict_command(input cmd_t cmd, input logic [BLK_W-1:0] blk,
                                   input logic clr);
        int          s;
        dir_result_t r;
        if (cmd == CMD_FLUSH_ALL) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (dirty_q[i]) begin
                    push_result(KIND_WB, tag_q[i], i);
                    dirty_q[i] = 1'b0;
                end
                if (clr) free_entry(i);
            end
            if (clr) use_cnt = '0;
            push_result(KIND_DONE, '0, 0);
        end else begin
            lookup_block(blk, s);
            if (s >= 0 && cmd == CMD_MARK_DIRTY) begin
                dirty_q[s] = 1'b1;
            end else if (s >= 0 && cmd == CMD_FLUSH_ONE) begin
                if (dirty_q[s]) begin
                    push_result(KIND_WB, tag_q[s], s);
                    dirty_q[s] = 1'b0;
                end
                if (clr) free_entry(s);
                push_result(KIND_DONE, '0, 0);
            end
        end
        // the final result of the transaction carries last
        r = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
    endtask

    task automatic check_result();
        dir_result_t got;
        dir_result_t want;
        got.kind = kind_t'(m_kind);
        got.blk  = m_block_out;
        got.slot = m_slot;
        got.last = m_last;
        results_seen++;
        if (got.kind == KIND_HIT) hits_seen++;
        if (got.kind == KIND_WB) wbs_seen++;
        if (got.kind == KIND_ERR) errs_seen++;
        if (expected_q.size() == 0) begin
            want = '0;
            report_mismatch("result with nothing expected", got, want);
        end else begin
            want = expected_q.pop_front();
            if (got !== want) report_mismatch("wrong field", got, want);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) free_entry(i);
            use_cnt = '0;
            limit_q = MAX_BLOCK_RST;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) check_result();
            if (cfg_wr_en) limit_q = cfg_wr_data;
            if (s_valid && s_ready) begin
                predict_command(cmd_t'(s_command), s_block_number, s_clear_entry);
            end
        end
        pending = expected_q.size();
    end

endmodule

@@ tb/sv/tb.sv @@
// testbench top of the lru block buffer cache unit: clock, reset, stimulus, verdict
// depends on lbc_pkg, the block and lbc_dir_checker
module tb
    import lbc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int POOL_SIZE   = 12;
    localparam int PHASE_ITEMS = 62;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [BLK_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_command = CMD_ACCESS;
    logic [BLK_W-1:0]  s_block_number = '0;
    logic              s_clear_entry = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [KIND_W-1:0] m_kind;
    logic [BLK_W-1:0]  m_block_out;
    logic [SLOT_W-1:0] m_slot;
    logic              m_last;

    int fail_count;
    int pending;
    int results_seen;
    int hits_seen;
    int wbs_seen;
    int errs_seen;

    int               items_sent = 0;
    int               limits_set = 0;
    int               quiet_cycles = 0;
    int               hold_asked = 0;
    int               hold_done = 0;
    bit               idle_on = 1'b1;
    logic [BLK_W-1:0] limit_now = MAX_BLOCK_RST;
    logic [BLK_W-1:0] pool [POOL_SIZE];

    lru_block_buffer_cache_unit #(
        .ENTRIES(ENTRIES_DEF)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_block_number (s_block_number),
        .s_clear_entry  (s_clear_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_block_out    (m_block_out),
        .m_slot         (m_slot),
        .m_last         (m_last)
    );

    lbc_dir_checker #(
        .ENTRIES(ENTRIES_DEF)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_block_number (s_block_number),
        .s_clear_entry  (s_clear_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_block_out    (m_block_out),
        .m_slot         (m_slot),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .hits_seen      (hits_seen),
        .wbs_seen       (wbs_seen),
        .errs_seen      (errs_seen)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("lru_block_buffer_cache_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_done) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_done++;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_ready = 1'b0;
                n = $urandom_range(1, 15);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_txn(input cmd_t cmd, input logic [BLK_W-1:0] blk, input logic clr);
        int n;
        @(negedge aclk);
        s_valid        = 1'b1;
        s_command      = cmd;
        s_block_number = blk;
        s_clear_entry  = clr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // stop offering, let every expected result come back, then let the sequencer settle
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (2 * ENTRIES_DEF + 8) @(negedge aclk);
    endtask

    task automatic set_limit(input logic [BLK_W-1:0] value);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        limit_now = value;
        limits_set++;
    endtask

    function automatic logic [BLK_W-1:0] pick_block();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return TAG_FREE;
        else if (r == 1) return limit_now + 1'b1;
        else if (r == 2) return BLK_W'($urandom_range(0, 65535));
        else return pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // mostly reuse a small pool of blocks so hits and evictions are common
    task automatic run_random(input int count, input int hold_at);
        int   r;
        cmd_t cmd;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                for (int k = 0; k < POOL_SIZE; k++) begin
                    pool[k] = BLK_W'($urandom_range(0, limit_now));
                end
            end
            if (i == hold_at) hold_asked++;
            r = $urandom_range(0, 99);
            if (r < 45) cmd = CMD_ACCESS;
            else if (r < 75) cmd = CMD_MARK_DIRTY;
            else if (r < 92) cmd = CMD_FLUSH_ONE;
            else cmd = CMD_FLUSH_ALL;
            send_txn(cmd, pick_block(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        set_limit(MAX_BLOCK_RST);
        send_txn(CMD_ACCESS, 16'h0000, 1'b0);
        send_txn(CMD_ACCESS, 16'hFFFE, 1'b0);
        send_txn(CMD_ACCESS, TAG_FREE, 1'b0);         // free marker is refused
        send_txn(CMD_ACCESS, 16'h0000, 1'b0);
        send_txn(CMD_MARK_DIRTY, 16'h0000, 1'b0);
        send_txn(CMD_FLUSH_ONE, 16'h0000, 1'b0);
        send_txn(CMD_MARK_DIRTY, 16'h5555, 1'b0);
        send_txn(CMD_FLUSH_ONE, 16'hAAAA, 1'b1);      // miss then clear a clean slot
        send_txn(CMD_FLUSH_ONE, 16'h5555, 1'b1);
        // fill the free slots with dirty blocks, then evict a clean victim and a dirty one
        for (int k = 0; k < 7; k++) send_txn(CMD_MARK_DIRTY, 16'h0100 + k, 1'b0);
        send_txn(CMD_ACCESS, 16'h0200, 1'b0);
        send_txn(CMD_ACCESS, 16'h0201, 1'b0);
        send_txn(CMD_FLUSH_ALL, 16'hFFFF, 1'b0);
        send_txn(CMD_FLUSH_ALL, 16'h0000, 1'b1);
        send_txn(CMD_FLUSH_ALL, 16'h0000, 1'b0);      // empty cache: done only

        set_limit(16'h0000);
        send_txn(CMD_ACCESS, 16'h0000, 1'b0);
        send_txn(CMD_ACCESS, 16'h0001, 1'b0);         // just above the limit
        send_txn(CMD_FLUSH_ONE, 16'h8000, 1'b1);
        send_txn(CMD_MARK_DIRTY, 16'h0000, 1'b0);
        send_txn(CMD_FLUSH_ONE, 16'h0000, 1'b1);

        set_limit(MAX_BLOCK_RST);
        run_random(PHASE_ITEMS, -1);
        set_limit(16'h0FFF);
        run_random(PHASE_ITEMS, 10);
        set_limit(16'h000B);
        run_random(PHASE_ITEMS, -1);
        set_limit(BLK_W'($urandom_range(16, 65534)));
        run_random(PHASE_ITEMS, -1);
        set_limit(MAX_BLOCK_RST);
        idle_on = 1'b0;
        run_random(PHASE_ITEMS, -1);
        drain();

        $display("sent %0d transactions under %0d max_block settings, checked %0d results",
                 items_sent, limits_set, results_seen);
        $display("hits %0d, writebacks %0d, errors %0d, mismatches %0d",
                 hits_seen, wbs_seen, errs_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("lru_block_buffer_cache_unit test passed");
        end else begin
            $display("lru_block_buffer_cache_unit test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lbc_pkg.sv
rtl/core/lbc_slot_store.sv
rtl/core/lbc_cmp_unit.sv
rtl/core/lru_block_buffer_cache_unit.sv
tb/sv/lbc_dir_checker.sv
tb/sv/tb.sv
